// ===== hdl/interpolated_color_lookup_macros.svh =====
// Assertion macros for the interpolated color lookup block.
// Used by the RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef INTERPOLATED_COLOR_LOOKUP_MACROS_SVH
`define INTERPOLATED_COLOR_LOOKUP_MACROS_SVH

// Plain invariant, checked at every clock edge out of reset.
`define ICL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ICL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ICL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/icl_pkg.sv =====
// Shared types, codes and reset contents for the interpolated color lookup.
// No dependencies; compiled before the interfaces and modules.
`timescale 1ns / 1ps

package icl_pkg;

  localparam int CH_W = 16;
  localparam int CH_N = 4;

  typedef logic [CH_N*CH_W-1:0] entry_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Red in the low channel, alpha in the high channel.
  localparam entry_t ENTRY_BLACK = {16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
  localparam entry_t ENTRY_WHITE = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Contents of an entry that has not been written since reset.
  function automatic entry_t default_entry(input logic [7:0] addr);
    entry_t e;
    e = '0;
    if (addr == 8'd0) begin
      e = ENTRY_BLACK;
    end else if (addr == 8'd1) begin
      e = ENTRY_WHITE;
    end
    return e;
  endfunction

endpackage

// ===== hdl/icl_ifs.sv =====
// Channel interfaces of the interpolated color lookup: item, color and config.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

interface icl_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         entry_index;
  logic [15:0]        entry_red;
  logic [15:0]        entry_green;
  logic [15:0]        entry_blue;
  logic [15:0]        entry_alpha;
  logic signed [17:0] query_value;

  modport source (output valid, operation, entry_index, entry_red, entry_green,
                  entry_blue, entry_alpha, query_value, input ready);
  modport sink   (input valid, operation, entry_index, entry_red, entry_green,
                  entry_blue, entry_alpha, query_value, output ready);
endinterface

interface icl_color_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface icl_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/icl_table.sv =====
// Color table memory: one write port, two registered read ports.
// Unwritten entries read as their reset color via per-entry valid bits. Uses icl_pkg.
`timescale 1ns / 1ps

module icl_table #(
  parameter int  MEM_DEPTH = 256,
  localparam int AW        = $clog2(MEM_DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  icl_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]   wr_addr,
  input  icl_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_lo_addr,
  input  logic [AW-1:0]   rd_hi_addr,
  output icl_pkg::entry_t lo_data,
  output icl_pkg::entry_t hi_data
);
  import icl_pkg::*;

  entry_t               mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] entry_valid;
  entry_t               lo_raw;
  entry_t               hi_raw;
  logic                 lo_vld;
  logic                 hi_vld;
  logic [AW-1:0]        lo_addr;
  logic [AW-1:0]        hi_addr;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      lo_raw  <= mem[rd_lo_addr];
      hi_raw  <= mem[rd_hi_addr];
      lo_addr <= rd_lo_addr;
      hi_addr <= rd_hi_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      lo_vld      <= 1'b0;
      hi_vld      <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        lo_vld <= entry_valid[rd_lo_addr];
        hi_vld <= entry_valid[rd_hi_addr];
      end
    end
  end

  assign lo_data = lo_vld ? lo_raw : default_entry(8'(lo_addr));
  assign hi_data = hi_vld ? hi_raw : default_entry(8'(hi_addr));

endmodule

// ===== hdl/interpolated_color_lookup.sv =====
// Top level of the interpolated RGBA color lookup.
// Depends on icl_pkg, icl_ifs, icl_table and interpolated_color_lookup_macros.svh.
`timescale 1ns / 1ps

// Usage
//   item  : input transactions. operation = write stores entry_index with the four
//           entry channels (indexes at or beyond TABLE_DEPTH are dropped, no result);
//           operation = query maps the signed Q2.16 query_value to one color.
//   color : one result transaction per query, in order, channels as 16-bit fractions.
//   cfg   : writes last_index (number of intervals); cfg.ready is always high.
//           Write it only while no query is in flight.
// Throughput: one item per cycle, sustained while color.ready stays high. The table's
//   two read ports fetch both interpolation endpoints at once.
// Pipeline: a query's scale product is registered on acceptance, then come the table
//   read, the channel multiply and the add into the output register.
// Reset: last_index returns to 1 and the per-entry valid bits clear, so the table
//   reads as entry 0 black, entry 1 white, all others zero. No sweep.
// Stall: while color.ready is low the result holds; the stages behind it keep
//   filling bubbles and item.ready drops only once every stage is occupied.
// Writes and queries meet the table in the same stage, so each query sees exactly
// the writes accepted before it.

module interpolated_color_lookup #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  icl_item_if.sink    item,
  icl_color_if.source color,
  icl_cfg_if.sink     cfg
);
  import icl_pkg::*;

  `include "interpolated_color_lookup_macros.svh"

  // Only 8-bit indexes can be written or read, so the memory never exceeds 256.
  localparam int MEM_DEPTH = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int LAST_MAX  = MEM_DEPTH - 1;
  localparam int SC_W      = 17 + 8;

  // ---------------------------------------------------------------- config
  logic [7:0] last_index;
  logic [7:0] last_lo;
  logic [7:0] last_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= 8'd1;
    end else if (cfg.valid) begin
      last_index <= cfg.data;
    end
  end

  // Zero counts as one interval; clamp to the table.
  assign last_lo  = (last_index == 8'd0) ? 8'd1 : last_index;
  assign last_eff = (last_lo > 8'(LAST_MAX)) ? 8'(LAST_MAX) : last_lo;

  // ---------------------------------------------------------------- flow control
  logic o_valid;
  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic out_en;
  logic s3_free;
  logic s2_free;
  logic s1_free;
  logic s1_query;

  assign out_en  = !o_valid || color.ready;
  assign s3_free = !s3_valid || out_en;
  assign s2_free = !s2_valid || s3_free;
  // Writes retire in stage 1 and never wait on the stages behind.
  assign s1_free = !s1_valid || !s1_query || s2_free;

  assign item.ready = s1_free;

  // ---------------------------------------------------------------- stage 1
  logic [SC_W-1:0] s1_scaled;
  logic            s1_neg;
  logic            s1_wr_ok;
  logic [AW-1:0]   s1_waddr;
  entry_t          s1_wdata;
  logic [SC_W-1:0] scaled_next;

  // Scale the non-negative magnitude by the interval count on entry.
  assign scaled_next = SC_W'(item.query_value[16:0]) * SC_W'(last_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && item.valid) begin
      s1_query  <= (item.operation == OP_QUERY);
      s1_neg    <= item.query_value[17];
      s1_scaled <= scaled_next;
      s1_wr_ok  <= (int'(item.entry_index) < TABLE_DEPTH);
      s1_waddr  <= item.entry_index[AW-1:0];
      s1_wdata  <= {item.entry_alpha, item.entry_blue, item.entry_green, item.entry_red};
    end
  end

  // Pick the endpoints. Outside the interpolating range read one entry with a zero
  // fraction, which passes that entry through the blend unchanged.
  logic [8:0]    ip;
  logic          interp;
  logic [AW-1:0] rd_lo;
  logic [AW-1:0] rd_hi;
  logic [15:0]   rd_frac;
  mem_ctl_t      ctl;

  assign ip     = s1_scaled[SC_W-1:16];
  assign interp = !s1_neg && (ip < {1'b0, last_eff});

  always_comb begin
    priority if (s1_neg) begin
      rd_lo   = '0;
      rd_hi   = '0;
      rd_frac = '0;
    end else if (interp) begin
      rd_lo   = ip[AW-1:0];
      rd_hi   = ip[AW-1:0] + AW'(1);
      rd_frac = s1_scaled[15:0];
    end else begin
      rd_lo   = last_eff[AW-1:0];
      rd_hi   = last_eff[AW-1:0];
      rd_frac = '0;
    end
  end

  assign ctl.wr_en = s1_valid && !s1_query && s1_wr_ok;
  assign ctl.rd_en = s1_valid && s1_query && s2_free;

  // ---------------------------------------------------------------- stage 2: table
  entry_t      lo_data;
  entry_t      hi_data;
  logic [15:0] s2_frac;

  icl_table #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .wr_addr    (s1_waddr),
    .wr_data    (s1_wdata),
    .rd_lo_addr (rd_lo),
    .rd_hi_addr (rd_hi),
    .lo_data    (lo_data),
    .hi_data    (hi_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && s1_query;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      s2_frac <= rd_frac;
    end
  end

  // Blend as a + (b - a) * f / 65536 with a floor, equal to the truncated
  // weighted sum of both endpoints.
  logic signed [33:0] prod_next [CH_N];

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      prod_next[c] = 34'($signed({1'b0, hi_data[c*CH_W +: CH_W]}) -
                         $signed({1'b0, lo_data[c*CH_W +: CH_W]})) *
                     34'($signed({1'b0, s2_frac}));
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [CH_W-1:0]    s3_base [CH_N];
  logic signed [33:0] s3_prod [CH_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid) begin
      for (int c = 0; c < CH_N; c++) begin
        s3_base[c] <= lo_data[c*CH_W +: CH_W];
        s3_prod[c] <= prod_next[c];
      end
    end
  end

  logic [17:0]  sum_next [CH_N];
  logic [63:0]  o_data;
  logic [63:0]  o_data_next;

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      sum_next[c] = {2'b00, s3_base[c]} + 18'(s3_prod[c][33:16]);
      o_data_next[c*CH_W +: CH_W] = sum_next[c][15:0];
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_en) begin
      o_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s3_valid) begin
      o_data <= o_data_next;
    end
  end

  assign color.valid     = o_valid;
  assign color.out_red   = o_data[15:0];
  assign color.out_green = o_data[31:16];
  assign color.out_blue  = o_data[47:32];
  assign color.out_alpha = o_data[63:48];

  // ---------------------------------------------------------------- checks
  `ICL_ASSERT(a_one_access, !(ctl.wr_en && ctl.rd_en), "table write and read in one cycle")
  `ICL_ASSERT_IMPL(a_ready_empty, !s1_valid, item.ready, "item not taken with stage 1 empty")
  `ICL_ASSERT_NEXT(a_s2_hold, s2_valid && !s3_free, s2_valid && $stable(s2_frac),
                   "stage 2 lost its query under stall")
  `ICL_ASSERT_NEXT(a_out_hold, o_valid && !color.ready, o_valid && $stable(o_data),
                   "stalled result changed")

endmodule
